@@ design/lexc_pkg.sv @@
`timescale 1ns / 1ps

package lexc_pkg;

  localparam int MAX_LEN = 16;
  localparam int LEN_W = $clog2(MAX_LEN + 2);
  localparam int ENTRIES = 64;
  localparam int ADDR_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int CNT_W = $clog2(ENTRIES + 1);
  localparam int IDX_W = 16;
  localparam int TBL_N = 34;

  localparam logic [2:0] CLS_ERROR = 3'd0;
  localparam logic [2:0] CLS_IDENT = 3'd1;
  localparam logic [2:0] CLS_NUMBER = 3'd2;
  localparam logic [2:0] CLS_KEYWORD = 3'd3;
  localparam logic [2:0] CLS_OPER = 3'd4;
  localparam logic [2:0] CLS_DELIM = 3'd5;

  localparam logic [1:0] RUN_NONE = 2'd0;
  localparam logic [1:0] RUN_ALNUM = 2'd1;
  localparam logic [1:0] RUN_OPER = 2'd2;
  localparam logic [1:0] RUN_SINGLE = 2'd3;

  typedef struct packed {
    logic match;
    logic digits;
  } cell_link_t;

  typedef struct packed {
    logic [IDX_W-1:0] idx;
    logic [LEN_W-1:0] len;
    logic [MAX_LEN*8-1:0] chars;
  } sym_row_t;

  typedef struct packed {
    logic hit;
    logic [2:0] cls;
    logic [5:0] code;
  } lookup_t;

  localparam logic [47:0] TBL_TEXT [TBL_N] = '{
    "if", "then", "else", "while", "do", "auto", "int", "double", "for", "void",
    "string", "cout",
    ">", "<", "=", ">=", "<=", "&&", "||", "+", "-", "*", "/", ">>", "<<", ":=",
    ";", "(", ")", "{", "}", "[", "]", "'"};
  localparam logic [2:0] TBL_LEN [TBL_N] = '{
    3'd2, 3'd4, 3'd4, 3'd5, 3'd2, 3'd4, 3'd3, 3'd6, 3'd3, 3'd4, 3'd6, 3'd4,
    3'd1, 3'd1, 3'd1, 3'd2, 3'd2, 3'd2, 3'd2, 3'd1, 3'd1, 3'd1, 3'd1, 3'd2,
    3'd2, 3'd2,
    3'd1, 3'd1, 3'd1, 3'd1, 3'd1, 3'd1, 3'd1, 3'd1};
  localparam logic [5:0] TBL_CODE [TBL_N] = '{
    6'd0, 6'd1, 6'd2, 6'd3, 6'd4, 6'd5, 6'd6, 6'd7, 6'd8, 6'd9, 6'd10, 6'd11,
    6'd12, 6'd13, 6'd14, 6'd15, 6'd16, 6'd17, 6'd18, 6'd19, 6'd20, 6'd21, 6'd22,
    6'd23, 6'd24, 6'd25,
    6'd26, 6'd27, 6'd28, 6'd29, 6'd30, 6'd31, 6'd32, 6'd34};

  // Matches the open token against the keyword, operator and delimiter lists.
  function automatic lookup_t table_lookup(input logic [MAX_LEN*8-1:0] chars,
                                           input logic [LEN_W-1:0] len);
    lookup_t res;
    logic eq;
    int pos;
    res = '0;
    for (int k = 0; k < TBL_N; k++) begin
      eq = (len == LEN_W'(TBL_LEN[k]));
      for (int j = 0; j < 6; j++) begin
        pos = (int'(TBL_LEN[k]) > j) ? (int'(TBL_LEN[k]) - 1 - j) : 0;
        if (j < int'(TBL_LEN[k]) && chars[j*8 +: 8] != TBL_TEXT[k][pos*8 +: 8]) begin
          eq = 1'b0;
        end
      end
      if (eq) begin
        res.hit = 1'b1;
        res.code = TBL_CODE[k];
        res.cls = (k < 12) ? CLS_KEYWORD : ((k < 26) ? CLS_OPER : CLS_DELIM);
      end
    end
    return res;
  endfunction

endpackage

@@ design/lexc_cell.sv @@
`timescale 1ns / 1ps

// One character position of the open token. Each cell adds its own compare
// result to the chain it gets from its left neighbor.
module lexc_cell (
  input  logic               clk,
  input  logic               load,
  input  logic [7:0]         load_char,
  input  logic               active,
  input  logic [7:0]         cmp_char,
  input  lexc_pkg::cell_link_t link_in,
  output lexc_pkg::cell_link_t link_out,
  output logic [7:0]         char_q
);

  always_ff @(posedge clk) begin
    if (load) begin
      char_q <= load_char;
    end
  end

  always_comb begin
    link_out.match = link_in.match & (~active | (char_q == cmp_char));
    link_out.digits = link_in.digits &
                      (~active | (char_q >= 8'h30 && char_q <= 8'h39));
  end

endmodule

@@ design/lexc_store.sv @@
`timescale 1ns / 1ps

// Symbol store: one row per identifier, read data registered.
module lexc_store (
  input  logic                        clk,
  input  logic                        wr_en,
  input  logic [lexc_pkg::ADDR_W-1:0] wr_addr,
  input  lexc_pkg::sym_row_t          wr_row,
  input  logic                        rd_en,
  input  logic [lexc_pkg::ADDR_W-1:0] rd_addr,
  output lexc_pkg::sym_row_t          rd_row
);

  lexc_pkg::sym_row_t mem [lexc_pkg::ENTRIES];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_row;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_row <= mem[rd_addr];
    end
  end

endmodule

@@ design/lexical_token_classifier.sv @@
`timescale 1ns / 1ps

// Lexical token classifier. Each request carries one text byte; tokens are
// cut at white space and at changes between alphanumeric runs, runs of the
// characters > = < | & : and single other characters. Each finished token
// leaves as one result with its class, table code, number value or
// identifier index, and last_of_run marks the final result of a byte. Each
// result passes through a flush, which classifies the open token, and the
// output state S_OUT. Before its output, an identifier is compared against
// the entries of the symbol store one row at a time, each compare a store
// read in S_SRCH and a row compare in S_CMP; a new identifier ends the
// search in S_SRCH and is recorded in S_NEW, or the store is reported full
// there. A result that waits in the output register holds the next result
// of the block until it is taken. The store starts empty after reset and
// needs no clearing pass.
module lexical_token_classifier (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  text_byte,
  input  logic        end_of_text,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  token_class,
  output logic [5:0]  token_code,
  output logic [15:0] ident_index,
  output logic [31:0] number_value,
  output logic        number_saturated,
  output logic        store_full,
  output logic        last_of_run
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_STEP = 3'd1;
  localparam logic [2:0] S_SRCH = 3'd2;
  localparam logic [2:0] S_CMP  = 3'd3;
  localparam logic [2:0] S_NEW  = 3'd4;
  localparam logic [2:0] S_OUT  = 3'd5;

  logic [2:0] state;

  // Work still to do for the current byte.
  logic do_a, do_b, do_c, do_d;
  logic [7:0] byte_q;
  logic [1:0] kind_q;
  logic [1:0] left;

  // Open token.
  logic [lexc_pkg::LEN_W-1:0] tok_len;
  logic [1:0] run_kind;
  logic [31:0] acc;
  logic acc_sat;
  logic [15:0] occ;
  logic [lexc_pkg::CNT_W-1:0] sym_count;
  logic [lexc_pkg::CNT_W-1:0] srch;

  // Result being built.
  logic [2:0] r_cls;
  logic [5:0] r_code;
  logic [15:0] r_idx;
  logic [31:0] r_val;
  logic r_sat;
  logic r_full;

  // Input byte decode.
  logic in_ws, in_digit, in_letter, in_op, in_alnum, in_other, in_open;
  logic [1:0] in_kind;
  logic a_n, c_n, d_n;

  always_comb begin
    in_ws = (text_byte == 8'h20) || (text_byte == 8'h0A) || (text_byte == 8'h09);
    in_digit = (text_byte >= 8'h30) && (text_byte <= 8'h39);
    in_letter = ((text_byte >= 8'h61) && (text_byte <= 8'h7A)) ||
                ((text_byte >= 8'h41) && (text_byte <= 8'h5A));
    in_op = (text_byte == 8'h3E) || (text_byte == 8'h3D) || (text_byte == 8'h3C) ||
            (text_byte == 8'h7C) || (text_byte == 8'h26) || (text_byte == 8'h3A);
    in_alnum = in_digit | in_letter;
    in_other = ~in_ws & ~in_alnum & ~in_op;
    in_kind = in_op ? lexc_pkg::RUN_OPER : (in_alnum ? lexc_pkg::RUN_ALNUM
                                                      : lexc_pkg::RUN_SINGLE);
    in_open = (run_kind != lexc_pkg::RUN_NONE);
    a_n = (in_alnum | in_op) ? (in_open && run_kind != in_kind) : in_open;
    c_n = in_other;
    d_n = end_of_text & ~in_ws & ~in_other;
  end

  assign in_ready = (state == S_IDLE);

  // Cell row holding the token characters.
  logic append;
  logic [lexc_pkg::MAX_LEN*8-1:0] tok_chars;
  lexc_pkg::cell_link_t links [lexc_pkg::MAX_LEN+1];
  lexc_pkg::sym_row_t rd_row;

  assign links[0] = '{match: 1'b1, digits: 1'b1};

  for (genvar i = 0; i < lexc_pkg::MAX_LEN; i++) begin : g_cell
    lexc_cell u_cell (
      .clk      (clk),
      .load     (append && (tok_len == lexc_pkg::LEN_W'(i))),
      .load_char(byte_q),
      .active   (tok_len > lexc_pkg::LEN_W'(i)),
      .cmp_char (rd_row.chars[i*8 +: 8]),
      .link_in  (links[i]),
      .link_out (links[i+1]),
      .char_q   (tok_chars[i*8 +: 8])
    );
  end

  // Symbol store.
  logic st_wr, st_rd;
  lexc_pkg::sym_row_t wr_row;

  always_comb begin
    wr_row.idx = occ;
    wr_row.len = tok_len;
    wr_row.chars = tok_chars;
  end

  lexc_store u_store (
    .clk    (clk),
    .wr_en  (st_wr),
    .wr_addr(sym_count[lexc_pkg::ADDR_W-1:0]),
    .wr_row (wr_row),
    .rd_en  (st_rd),
    .rd_addr(srch[lexc_pkg::ADDR_W-1:0]),
    .rd_row (rd_row)
  );

  // Classification of the open token.
  lexc_pkg::lookup_t lk;
  logic [2:0] cls_n;
  logic c0_letter;

  always_comb begin
    lk = lexc_pkg::table_lookup(tok_chars, tok_len);
    c0_letter = ((tok_chars[7:0] >= 8'h61) && (tok_chars[7:0] <= 8'h7A)) ||
                ((tok_chars[7:0] >= 8'h41) && (tok_chars[7:0] <= 8'h5A));
    if (tok_len > lexc_pkg::LEN_W'(lexc_pkg::MAX_LEN)) begin
      cls_n = lexc_pkg::CLS_ERROR;
    end else if (lk.hit) begin
      cls_n = lk.cls;
    end else if (run_kind == lexc_pkg::RUN_ALNUM && links[lexc_pkg::MAX_LEN].digits) begin
      cls_n = lexc_pkg::CLS_NUMBER;
    end else if (run_kind == lexc_pkg::RUN_ALNUM && c0_letter) begin
      cls_n = lexc_pkg::CLS_IDENT;
    end else begin
      cls_n = lexc_pkg::CLS_ERROR;
    end
  end

  // Decimal accumulate: acc * 10 + digit, saturating.
  logic [31:0] acc_base;
  logic sat_base;
  logic [35:0] acc_mul;

  always_comb begin
    acc_base = (run_kind == lexc_pkg::RUN_NONE) ? 32'd0 : acc;
    sat_base = (run_kind == lexc_pkg::RUN_NONE) ? 1'b0 : acc_sat;
    acc_mul = ({4'd0, acc_base} << 3) + ({4'd0, acc_base} << 1) +
              {32'd0, byte_q[3:0] - 4'd0};
  end

  logic do_flush;
  logic row_hit;

  always_comb begin
    append = (state == S_STEP) && !do_a && do_b;
    do_flush = (state == S_STEP) && (do_a || (!do_b && (do_c || do_d)));
    st_rd = (state == S_SRCH) && (srch != sym_count);
    st_wr = (state == S_NEW) && (sym_count < lexc_pkg::CNT_W'(lexc_pkg::ENTRIES));
    row_hit = (rd_row.len == tok_len) && links[lexc_pkg::MAX_LEN].match;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      do_a <= 1'b0;
      do_b <= 1'b0;
      do_c <= 1'b0;
      do_d <= 1'b0;
      left <= 2'd0;
      tok_len <= '0;
      run_kind <= lexc_pkg::RUN_NONE;
      acc <= 32'd0;
      acc_sat <= 1'b0;
      occ <= 16'd0;
      sym_count <= '0;
      srch <= '0;
      out_valid <= 1'b0;
    end else begin
      // A result taken while the next one is ready is replaced in S_OUT.
      if (out_valid && out_ready && state != S_OUT) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            byte_q <= text_byte;
            kind_q <= in_kind;
            do_a <= a_n;
            do_b <= ~in_ws;
            do_c <= c_n;
            do_d <= d_n;
            left <= 2'({1'b0, a_n} + {1'b0, c_n} + {1'b0, d_n});
            state <= S_STEP;
          end
        end
        S_STEP: begin
          if (do_a) begin
            do_a <= 1'b0;
          end else if (do_b) begin
            do_b <= 1'b0;
            if (run_kind == lexc_pkg::RUN_NONE) begin
              run_kind <= kind_q;
            end
            if (tok_len <= lexc_pkg::LEN_W'(lexc_pkg::MAX_LEN)) begin
              tok_len <= tok_len + 1'b1;
            end
            if (kind_q == lexc_pkg::RUN_ALNUM && byte_q >= 8'h30 && byte_q <= 8'h39) begin
              if (sat_base || acc_mul[35:32] != 4'd0) begin
                acc <= 32'hFFFF_FFFF;
                acc_sat <= 1'b1;
              end else begin
                acc <= acc_mul[31:0];
                acc_sat <= sat_base;
              end
            end else begin
              acc <= acc_base;
              acc_sat <= sat_base;
            end
            if (!do_c && !do_d) begin
              state <= S_IDLE;
            end
          end else if (do_c) begin
            do_c <= 1'b0;
          end else if (do_d) begin
            do_d <= 1'b0;
          end else begin
            state <= S_IDLE;
          end
          if (do_flush) begin
            r_cls <= cls_n;
            r_code <= (lk.hit && cls_n != lexc_pkg::CLS_ERROR) ? lk.code : 6'd0;
            r_idx <= 16'd0;
            r_val <= (cls_n == lexc_pkg::CLS_NUMBER) ? acc : 32'd0;
            r_sat <= (cls_n == lexc_pkg::CLS_NUMBER) ? acc_sat : 1'b0;
            r_full <= 1'b0;
            srch <= '0;
            state <= (cls_n == lexc_pkg::CLS_IDENT) ? S_SRCH : S_OUT;
          end
        end
        S_SRCH: begin
          state <= (srch == sym_count) ? S_NEW : S_CMP;
        end
        S_CMP: begin
          if (row_hit) begin
            r_idx <= rd_row.idx;
            occ <= occ + 16'd1;
            state <= S_OUT;
          end else begin
            srch <= srch + 1'b1;
            state <= S_SRCH;
          end
        end
        S_NEW: begin
          r_idx <= occ;
          occ <= occ + 16'd1;
          if (st_wr) begin
            sym_count <= sym_count + 1'b1;
          end else begin
            r_full <= 1'b1;
          end
          state <= S_OUT;
        end
        S_OUT: begin
          if (!out_valid || out_ready) begin
            out_valid <= 1'b1;
            token_class <= r_cls;
            token_code <= r_code;
            ident_index <= r_idx;
            number_value <= r_val;
            number_saturated <= r_sat;
            store_full <= r_full;
            last_of_run <= (left == 2'd1);
            left <= left - 2'd1;
            run_kind <= lexc_pkg::RUN_NONE;
            tok_len <= '0;
            state <= S_STEP;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // The store never holds more rows than it has.
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    sym_count <= lexc_pkg::CNT_W'(lexc_pkg::ENTRIES))
    else $error("symbol count beyond store size");

  // A row compare always follows the read that fetched it.
  a_cmp_after_read: assert property (@(posedge clk) disable iff (rst)
    state == S_CMP |-> $past(state) == S_SRCH)
    else $error("compare without a store read");

  // A full flag is only raised once the store has filled.
  a_full_only_when_full: assert property (@(posedge clk) disable iff (rst)
    state == S_OUT && r_full |-> sym_count == lexc_pkg::CNT_W'(lexc_pkg::ENTRIES))
    else $error("store full reported on a store with room");

  // A result is only sent while results of the current byte remain.
  a_result_pending: assert property (@(posedge clk) disable iff (rst)
    state == S_OUT |-> left != 2'd0)
    else $error("result with no result pending");

endmodule
